@@ rtl/core/emmc_aes_ctr_crypt_defines.svh @@
// Assertion macros for the storage crypt block.
`ifndef EMMC_AES_CTR_CRYPT_DEFINES_SVH
`define EMMC_AES_CTR_CRYPT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define EAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset.
`define EAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/eac_pkg.sv @@
// Package: types, constants and AES helper functions for the storage crypt block.
package eac_pkg;

  typedef struct packed {
    logic [15:0] block_index;
    logic [63:0] data_low;
    logic [63:0] data_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_low;
    logic [63:0] out_high;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_DEVICE_ID   = 2'd0,
    REG_ALT_MODE    = 2'd1,
    REG_CID_LOW     = 2'd2,
    REG_CID_HIGH    = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned Rounds    = 10;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [63:0] KeyYLo     = 64'hbd4dc4d30ab9dc76;
  localparam logic [63:0] KeyYHi     = 64'he1a00005202ddd1d;
  localparam logic [63:0] KeyMagicLo = 64'h2a680f5f1a4f3e79;
  localparam logic [63:0] KeyMagicHi = 64'hfffefb4e29590258;
  localparam int unsigned KeyRotate  = 42;

  localparam logic [31:0] HhMaskA  = 32'h24ee6906;
  localparam logic [31:0] HhMaskB  = 32'he65b601d;
  localparam logic [31:0] AltMaskL = 32'hb358a6af;
  localparam logic [31:0] AltTopBit = 32'h80000000;
  localparam logic [31:0] AltWord1 = 32'h544e494e;
  localparam logic [31:0] AltWord2 = 32'h4f444e45;
  localparam logic [31:0] AltMaskH = 32'h08c267b7;

  // Counter and data words passed from front to back.
  typedef struct packed {
    logic [127:0] ctr;
    logic [63:0]  data_low;
    logic [63:0]  data_high;
  } work_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [Rounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit big-endian word sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int unsigned i);
    return w[127-8*i -: 8];
  endfunction

  // SubBytes + ShiftRows (+ MixColumns when mix is set).
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0]   t [16];
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = SBOX[get_byte(s, i + 4*((c+i)%4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (mix) begin
        r[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
        r[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
        r[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
        r[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end else begin
        r[127-32*c -: 8] = a0;
        r[119-32*c -: 8] = a1;
        r[111-32*c -: 8] = a2;
        r[103-32*c -: 8] = a3;
      end
    end
    return r;
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    g  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ rtl/core/emmc_aes_ctr_crypt.sv @@
// Top level: storage AES-128-CTR crypt with device-derived key.
// Data path: the input queue, an initial key-add stage, then ten round stages.
// Throughput: one 16-byte block per cycle while the output is not held; the fully unrolled round pipeline sets it.
// A held output halts the round pipeline; the 4-entry queue absorbs input meanwhile.
// Reset clears config registers, key schedule registers, queue pointers and stage valid bits.
// Round keys are rebuilt after a device_id or mode write, through the config register, the key sum
// register and one register per round key; the round pipeline does not wait for them.
module emmc_aes_ctr_crypt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  eac_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output eac_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [eac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                  cfg_wdata_i
);
  import eac_pkg::*;
`include "emmc_aes_ctr_crypt_defines.svh"

  logic [63:0]  device_id_q, cid_low_q, cid_high_q;
  logic         alt_mode_q;
  logic [127:0] rk [11];
  logic         q_valid, q_pop;
  work_t        q_data;

  // Config register file; unused indexes cannot occur with a 2-bit index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= '0;
      alt_mode_q  <= 1'b0;
      cid_low_q   <= '0;
      cid_high_q  <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DEVICE_ID: device_id_q <= cfg_wdata_i;
        REG_ALT_MODE:  alt_mode_q  <= cfg_wdata_i[0];
        REG_CID_LOW:   cid_low_q   <= cfg_wdata_i;
        REG_CID_HIGH:  cid_high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  eac_keysched u_keys (
    .clk_i, .rst_ni,
    .device_id_i (device_id_q),
    .alt_mode_i  (alt_mode_q),
    .round_key_o (rk)
  );

  eac_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .ctr_base_i (({cid_high_q, cid_low_q})),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  eac_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .round_key_i (rk),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  // Queue is popped only when it has an entry.
  `EAC_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid)
  // A held result stays put while stalled.
  `EAC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  // Back pressure at the input implies a nonempty queue (it is raised only when the queue is full).
  `EAC_ASSERT_IMP(a_stall_full, in_stall_o, q_valid)

endmodule

@@ rtl/core/eac_keysched.sv @@
// Key derivation from the device ID and the full AES-128 round key schedule.
module eac_keysched (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       device_id_i,
  input  logic              alt_mode_i,
  output logic [127:0]      round_key_o [11]
);
  import eac_pkg::*;

  logic [31:0]  h, l, x0, x1, x2, x3;
  logic [127:0] k_x, s_d, s_q;
  logic [127:0] rk_q [11];

  assign h = device_id_i[63:32];
  assign l = device_id_i[31:0];

  always_comb begin
    if (alt_mode_i) begin
      x0 = (l ^ AltMaskL) | AltTopBit;
      x1 = AltWord1;
      x2 = AltWord2;
      x3 = h ^ AltMaskH;
    end else begin
      x0 = l;
      x1 = l ^ HhMaskA;
      x2 = h ^ HhMaskB;
      x3 = h;
    end
    k_x = {x3, x2, x1, x0} ^ {KeyYHi, KeyYLo};
    s_d = k_x + {KeyMagicHi, KeyMagicLo};
  end

  // Sum and rotation registered, then one key step per stage; the user must
  // hold traffic until keys settle after a config write (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
      for (int i = 0; i < 11; i++) rk_q[i] <= '0;
    end else begin
      s_q     <= s_d;
      rk_q[0] <= {s_q[127-KeyRotate:0], s_q[127 -: KeyRotate]};
      for (int i = 1; i < 11; i++) rk_q[i] <= key_step(rk_q[i-1], RCON[i-1]);
    end
  end

  assign round_key_o = rk_q;
endmodule

@@ rtl/core/eac_front.sv @@
// Front part: accepts input transfers, builds the counter and fills the queue.
module eac_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  eac_pkg::in_item_t in_data_i,
  input  logic [127:0]      ctr_base_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output eac_pkg::work_t    q_data_o
);
  import eac_pkg::*;

  work_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 push;
  work_t                w;

  assign in_stall_o = (cnt_q == QueueDepth[QueuePtrW:0]);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_q];

  always_comb begin
    w.ctr       = ctr_base_i + {112'd0, in_data_i.block_index};
    w.data_low  = in_data_i.data_low;
    w.data_high = in_data_i.data_high;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{QueuePtrW{1'b0}}, push} - {{QueuePtrW{1'b0}}, q_pop_i};
    end
  end
endmodule

@@ rtl/core/eac_back.sv @@
// Back part: pipelined AES-128 rounds and keystream XOR on the last stage's registers.
module eac_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  eac_pkg::work_t     q_data_i,
  input  logic [127:0]       round_key_i [11],
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output eac_pkg::out_item_t out_data_o
);
  import eac_pkg::*;

  localparam int unsigned NStg = Rounds + 1;

  logic         v_q  [NStg];
  logic [127:0] s_q  [NStg];
  logic [127:0] dl_q [NStg];
  logic         adv;
  logic [127:0] ks;

  // Whole pipeline moves together; halts only when the output is held.
  assign adv     = !(out_valid_o && out_stall_i);
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStg; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= q_valid_i;
      for (int i = 1; i < NStg; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0]  <= q_data_i.ctr ^ round_key_i[0];
      dl_q[0] <= {q_data_i.data_high, q_data_i.data_low};
      for (int i = 1; i < NStg; i++) begin
        s_q[i]  <= aes_round(s_q[i-1], i != Rounds) ^ round_key_i[i];
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  assign ks                  = s_q[NStg-1];
  assign out_valid_o         = v_q[NStg-1];
  assign out_data_o.out_low  = dl_q[NStg-1][63:0] ^ ks[63:0];
  assign out_data_o.out_high = dl_q[NStg-1][127:64] ^ ks[127:64];
endmodule
